// File: sv/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge, skipped while reset is high.
`define GSC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gsc assertion failed");
// Check a property on every rising clock edge, reset included.
`define GSC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("gsc assertion failed");
`endif

// File: sv/gsc_pkg.sv
// Shared types, constants and helpers of the segment clearance checker.
package gsc_pkg;
   localparam int GRID_ROWS   = 64;
   localparam int GRID_COLS   = 64;
   localparam int STACK_DEPTH = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int AW     = $clog2(CELLS);
   localparam int RW     = $clog2(GRID_ROWS);
   localparam int CW     = $clog2(GRID_COLS);
   localparam int SW     = $clog2(STACK_DEPTH);
   localparam int LW     = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_CPM      = 2'd2;

   localparam logic       CMD_WRITE = 1'b0;
   localparam logic       CMD_QUERY = 1'b1;

   localparam logic [31:0] CPM_RESET = 32'd1310720;

   typedef struct packed {
      logic               cmd;
      logic [5:0]         cell_row;
      logic [5:0]         cell_col;
      logic               cell_occupied;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } req_type;

   typedef struct packed {
      logic       is_clear;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic               is_query;
      logic               wr_ok;
      logic [AW-1:0]      wr_addr;
      logic               wr_occ;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
   } entry_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [31:0]        cpm;
   } cfg_type;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
      logic [AW+CW-1:0] a;
      a = (AW+CW)'(r) * (AW+CW)'(GRID_COLS) + (AW+CW)'(c);
      return a[AW-1:0];
   endfunction
endpackage

// File: sv/gsc_ram.sv
// Generic single-port RAM with registered read data.
module gsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/gsc_front.sv
// Front end: classifies request transactions into queue entries.
module gsc_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  gsc_pkg::req_type    req_data,
   output logic                push,
   output gsc_pkg::entry_type  entry,
   input  logic                q_full
);
   logic row_ok;
   logic col_ok;

   // check the write target against the grid bounds
   assign row_ok = 32'(req_data.cell_row) < 32'(gsc_pkg::GRID_ROWS);
   assign col_ok = 32'(req_data.cell_col) < 32'(gsc_pkg::GRID_COLS);

   always_comb begin
      entry          = '0;
      entry.is_query = (req_data.cmd == gsc_pkg::CMD_QUERY);
      entry.wr_ok    = row_ok && col_ok;
      entry.wr_addr  = gsc_pkg::cell_addr(req_data.cell_row[gsc_pkg::RW-1:0],
                                          req_data.cell_col[gsc_pkg::CW-1:0]);
      entry.wr_occ   = req_data.cell_occupied;
      entry.sx       = req_data.start_x;
      entry.sy       = req_data.start_y;
      entry.ex       = req_data.end_x;
      entry.ey       = req_data.end_y;
   end

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;
endmodule

// File: sv/gsc_queue.sv
// Short FIFO between the front end and the segment engine.
`include "assert_macros.svh"
module gsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gsc_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output gsc_pkg::entry_type pop_data
);
   localparam int PW = $clog2(gsc_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(gsc_pkg::QUEUE_DEPTH + 1);

   gsc_pkg::entry_type slot_ff [gsc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full      = (count_ff == NW'(gsc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(gsc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(gsc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `GSC_ASSERT(a_no_overfill, clock, reset, full |-> !push)
   `GSC_ASSERT(a_no_underflow, clock, reset, !not_empty |-> !pop)
   `GSC_ASSERT(a_count_bound, clock, reset, count_ff <= NW'(gsc_pkg::QUEUE_DEPTH))
endmodule

// File: sv/gsc_back.sv
// Segment engine: grid writes and depth-first bisection of query segments.
`include "assert_macros.svh"
module gsc_back (
   input  logic               clock,
   input  logic               reset,
   input  gsc_pkg::cfg_type   cfg,
   input  logic               q_not_empty,
   input  gsc_pkg::entry_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gsc_pkg::rsp_type   rsp_data
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_POP, S_SEG, S_CMUL, S_CCHK, S_RD_M, S_CK_M,
      S_RD_A, S_CK_A, S_RD_B, S_CK_B, S_PUSH_HI, S_PUSH_LO, S_NEXT, S_FINISH
   } state_type;

   localparam int RW = gsc_pkg::RW;
   localparam int CW = gsc_pkg::CW;
   localparam int AW = gsc_pkg::AW;

   state_type           state_ff;
   logic [AW-1:0]       clr_ff;
   logic signed [31:0]  ax_ff, ay_ff, bx_ff, by_ff, mx_ff, my_ff;
   logic [RW-1:0]       ar_ff, br_ff, mr_ff;
   logic [CW-1:0]       ac_ff, bc_ff, mc_ff;
   logic [2:0]          k_ff;
   logic [63:0]         prod_ff;
   logic                neg_ff;
   logic                outside_ff;
   logic [gsc_pkg::LW-1:0] lvl_ff;
   logic [63:0]         stk_start_ff [gsc_pkg::STACK_DEPTH];
   logic [63:0]         stk_end_ff   [gsc_pkg::STACK_DEPTH];
   logic                res_clear_ff;
   logic [1:0]          res_status_ff;
   logic                rsp_valid_ff;
   gsc_pkg::rsp_type    rsp_ff;

   logic                ram_we;
   logic [AW-1:0]       ram_addr;
   logic                ram_wdata;
   logic                ram_rdata;
   logic signed [31:0]  p_sel, o_sel;
   logic [32:0]         d_in;
   logic [63:0]         prod_in;
   logic [31:0]         lim;
   logic                cell_out;
   logic [32:0]         sum_x, sum_y;
   logic                adj, unsplit, b_ne_m, a_ne_m;
   logic [gsc_pkg::SW-1:0] top_idx, push_idx;

   gsc_ram #(.WIDTH(1), .DEPTH(gsc_pkg::CELLS)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = 1'b0;
      ram_addr  = gsc_pkg::cell_addr(mr_ff, mc_ff);
      case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
         end
         S_IDLE: begin
            ram_addr  = q_data.wr_addr;
            ram_wdata = q_data.wr_occ;
            ram_we    = q_not_empty && !q_data.is_query && q_data.wr_ok;
         end
         S_RD_A:  ram_addr = gsc_pkg::cell_addr(ar_ff, ac_ff);
         S_RD_B:  ram_addr = gsc_pkg::cell_addr(br_ff, bc_ff);
         default: ram_addr = gsc_pkg::cell_addr(mr_ff, mc_ff);
      endcase
   end

   assign q_pop = (state_ff == S_IDLE) && q_not_empty;

   // select one coordinate per multiply step: start, end, midpoint; x then y
   always_comb begin
      case (k_ff)
         3'd0:    begin p_sel = ax_ff; o_sel = cfg.origin_x; end
         3'd1:    begin p_sel = ay_ff; o_sel = cfg.origin_y; end
         3'd2:    begin p_sel = bx_ff; o_sel = cfg.origin_x; end
         3'd3:    begin p_sel = by_ff; o_sel = cfg.origin_y; end
         3'd4:    begin p_sel = mx_ff; o_sel = cfg.origin_x; end
         default: begin p_sel = my_ff; o_sel = cfg.origin_y; end
      endcase
      d_in    = {p_sel[31], p_sel} - {o_sel[31], o_sel};
      prod_in = 64'(d_in[31:0]) * 64'(cfg.cpm);
      lim     = k_ff[0] ? 32'(gsc_pkg::GRID_ROWS) : 32'(gsc_pkg::GRID_COLS);
      cell_out = neg_ff || (prod_ff[63:32] >= lim);
   end

   assign sum_x   = {ax_ff[31], ax_ff} + {bx_ff[31], bx_ff};
   assign sum_y   = {ay_ff[31], ay_ff} + {by_ff[31], by_ff};
   assign adj     = ((ar_ff == br_ff) && (({1'b0, ac_ff} == {1'b0, bc_ff} + 1'b1) ||
                                          ({1'b0, bc_ff} == {1'b0, ac_ff} + 1'b1))) ||
                    ((ac_ff == bc_ff) && (({1'b0, ar_ff} == {1'b0, br_ff} + 1'b1) ||
                                          ({1'b0, br_ff} == {1'b0, ar_ff} + 1'b1)));
   assign unsplit = ((mx_ff == ax_ff) && (my_ff == ay_ff)) ||
                    ((mx_ff == bx_ff) && (my_ff == by_ff));
   assign b_ne_m  = (br_ff != mr_ff) || (bc_ff != mc_ff);
   assign a_ne_m  = (ar_ff != mr_ff) || (ac_ff != mc_ff);
   assign top_idx  = lvl_ff[gsc_pkg::SW-1:0] - 1'b1;
   assign push_idx = lvl_ff[gsc_pkg::SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(gsc_pkg::CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_not_empty) begin
                  ax_ff <= q_data.sx;
                  ay_ff <= q_data.sy;
                  bx_ff <= q_data.ex;
                  by_ff <= q_data.ey;
                  lvl_ff <= '0;
                  res_clear_ff  <= 1'b0;
                  res_status_ff <= q_data.wr_ok ? gsc_pkg::STATUS_OK
                                                : gsc_pkg::STATUS_OUTSIDE;
                  state_ff <= q_data.is_query ? S_SEG : S_FINISH;
               end
            end
            S_POP: begin
               {ax_ff, ay_ff} <= stk_start_ff[top_idx];
               {bx_ff, by_ff} <= stk_end_ff[top_idx];
               lvl_ff   <= lvl_ff - 1'b1;
               state_ff <= S_SEG;
            end
            S_SEG: begin
               mx_ff      <= sum_x[32:1];
               my_ff      <= sum_y[32:1];
               k_ff       <= '0;
               outside_ff <= 1'b0;
               state_ff   <= ((ax_ff == bx_ff) && (ay_ff == by_ff)) ? S_NEXT : S_CMUL;
            end
            S_CMUL: begin
               prod_ff  <= prod_in;
               neg_ff   <= d_in[32];
               state_ff <= S_CCHK;
            end
            S_CCHK: begin
               if (cell_out) begin
                  outside_ff <= 1'b1;
               end
               case (k_ff)
                  3'd0:    ac_ff <= prod_ff[32 +: CW];
                  3'd1:    ar_ff <= prod_ff[32 +: RW];
                  3'd2:    bc_ff <= prod_ff[32 +: CW];
                  3'd3:    br_ff <= prod_ff[32 +: RW];
                  3'd4:    mc_ff <= prod_ff[32 +: CW];
                  default: mr_ff <= prod_ff[32 +: RW];
               endcase
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd5) begin
                  if (outside_ff || cell_out) begin
                     res_status_ff <= gsc_pkg::STATUS_OUTSIDE;
                     state_ff      <= S_FINISH;
                  end else begin
                     state_ff <= S_RD_M;
                  end
               end else begin
                  state_ff <= S_CMUL;
               end
            end
            S_RD_M: state_ff <= S_CK_M;
            S_CK_M: begin
               if (ram_rdata) begin
                  state_ff <= S_FINISH;
               end else if ((ar_ff == br_ff) && (ac_ff == bc_ff)) begin
                  state_ff <= S_NEXT;
               end else if (adj || unsplit) begin
                  state_ff <= S_RD_A;
               end else begin
                  state_ff <= S_PUSH_HI;
               end
            end
            S_RD_A: state_ff <= S_CK_A;
            S_CK_A: state_ff <= ram_rdata ? S_FINISH : S_RD_B;
            S_RD_B: state_ff <= S_CK_B;
            S_CK_B: state_ff <= ram_rdata ? S_FINISH : S_NEXT;
            S_PUSH_HI: begin
               state_ff <= S_PUSH_LO;
               if (b_ne_m) begin
                  if (lvl_ff == gsc_pkg::LW'(gsc_pkg::STACK_DEPTH)) begin
                     res_status_ff <= gsc_pkg::STATUS_OVERFLOW;
                     state_ff      <= S_FINISH;
                  end else begin
                     lvl_ff <= lvl_ff + 1'b1;
                  end
               end
            end
            S_PUSH_LO: begin
               state_ff <= S_NEXT;
               if (a_ne_m) begin
                  if (lvl_ff == gsc_pkg::LW'(gsc_pkg::STACK_DEPTH)) begin
                     res_status_ff <= gsc_pkg::STATUS_OVERFLOW;
                     state_ff      <= S_FINISH;
                  end else begin
                     lvl_ff <= lvl_ff + 1'b1;
                  end
               end
            end
            S_NEXT: begin
               if (lvl_ff == '0) begin
                  res_clear_ff <= 1'b1;
                  state_ff     <= S_FINISH;
               end else begin
                  state_ff <= S_POP;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.is_clear  <= res_clear_ff;
                  rsp_ff.status    <= res_status_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      // stack entries carry no reset; only pushed entries are popped
      if (!reset && (lvl_ff != gsc_pkg::LW'(gsc_pkg::STACK_DEPTH))) begin
         if ((state_ff == S_PUSH_HI) && b_ne_m) begin
            stk_start_ff[push_idx] <= {mx_ff, my_ff};
            stk_end_ff[push_idx]   <= {bx_ff, by_ff};
         end else if ((state_ff == S_PUSH_LO) && a_ne_m) begin
            stk_start_ff[push_idx] <= {ax_ff, ay_ff};
            stk_end_ff[push_idx]   <= {mx_ff, my_ff};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GSC_ASSERT(a_lvl_bound, clock, reset, lvl_ff <= gsc_pkg::LW'(gsc_pkg::STACK_DEPTH))
   `GSC_ASSERT(a_no_take_in_clear, clock, reset, (state_ff == S_CLEAR) |-> !q_pop)
   `GSC_ASSERT(a_clear_means_ok, clock, reset,
      (rsp_valid_ff && rsp_ff.is_clear) |-> (rsp_ff.status == gsc_pkg::STATUS_OK))
endmodule

// File: sv/grid_segment_clearance_check_top.sv
// Top level of the grid segment clearance checker.
// A cell write raises rsp_valid once it has left the queue and passed S_FINISH; a query needs,
// per sub-segment, cell conversion on the single shared 32x32 multiplier, grid reads on the
// one RAM port and stack work.
// Throughput: one item at a time in the engine; a 2-entry queue keeps requests flowing.
// Reset (synchronous, active high) restores the registers and then runs a clearing
// pass over all GRID_ROWS*GRID_COLS cells (4096) of the grid before any item is taken.
module grid_segment_clearance_check_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gsc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   gsc_pkg::cfg_type   cfg_ff;
   gsc_pkg::entry_type push_entry;
   gsc_pkg::entry_type pop_entry;
   logic               push;
   logic               q_full;
   logic               q_not_empty;
   logic               q_pop;

   // hold the configuration registers; writes must arrive only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.cpm      <= gsc_pkg::CPM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            gsc_pkg::CSR_ORIGIN_X: cfg_ff.origin_x <= csr_wdata;
            gsc_pkg::CSR_ORIGIN_Y: cfg_ff.origin_y <= csr_wdata;
            gsc_pkg::CSR_CPM:      cfg_ff.cpm      <= csr_wdata;
            default:               cfg_ff          <= cfg_ff;
         endcase
      end
   end

   // classify each request transaction and drop it into the queue
   gsc_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .entry     (push_entry),
      .q_full    (q_full)
   );

   // decouple the front end from the engine
   gsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_entry)
   );

   // advance writes and bisection queries, one at a time
   gsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (pop_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );
endmodule

// File: dv/tb.sv
// Self-checking testbench for grid_segment_clearance_check_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   gsc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   gsc_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = gsc_pkg::CSR_ORIGIN_X;
   logic [31:0]      csr_wdata = '0;

   grid_segment_clearance_check_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow copy of the block's map and settings.
   bit          occ_map [0:gsc_pkg::CELLS-1];
   longint      org_x, org_y;
   bit [31:0]   cpm;

   gsc_pkg::req_type pending_items [$];
   gsc_pkg::rsp_type due_answers [$];
   int          idle_pct = 10;
   int          mismatches = 0;
   logic        hold_go = 1'b0;
   int          hold_left = 0;

   // Map a world coordinate to a cell index; returns 0 when below the origin or past the grid.
   function automatic bit world_to_cell(input longint p, input longint org,
                                        output longint idx);
      longint    d;
      bit [63:0] du, prod;
      d = p - org;
      idx = 0;
      if (d < 0) return 1'b0;
      du = d;
      prod = du * {32'b0, cpm};     // wraps at 64 bits like the block
      idx = longint'(prod >> 32);
      return idx < gsc_pkg::GRID_COLS;       // grid is square
   endfunction

   // Depth-first bisection of one segment against the shadow map.
   function automatic gsc_pkg::rsp_type segment_verdict(input longint sx, input longint sy,
                                                        input longint ex, input longint ey);
      longint  st_ax [gsc_pkg::STACK_DEPTH], st_ay [gsc_pkg::STACK_DEPTH];
      longint  st_bx [gsc_pkg::STACK_DEPTH], st_by [gsc_pkg::STACK_DEPTH];
      int      lvl;
      longint  ax, ay, bx, by, mx, my;
      longint  ar, ac, br, bc, mr, mc, dr, dc;
      bit      unsplit;
      gsc_pkg::rsp_type v;
      v.is_clear = 1'b0;
      v.status = gsc_pkg::STATUS_OK;
      st_ax[0] = sx; st_ay[0] = sy; st_bx[0] = ex; st_by[0] = ey;
      lvl = 1;
      while (lvl > 0) begin
         lvl--;
         ax = st_ax[lvl]; ay = st_ay[lvl]; bx = st_bx[lvl]; by = st_by[lvl];
         if (ax == bx && ay == by) continue;
         mx = (ax + bx) >>> 1;
         my = (ay + by) >>> 1;
         if (!world_to_cell(ax, org_x, ac) || !world_to_cell(ay, org_y, ar) ||
             !world_to_cell(bx, org_x, bc) || !world_to_cell(by, org_y, br) ||
             !world_to_cell(mx, org_x, mc) || !world_to_cell(my, org_y, mr)) begin
            v.status = gsc_pkg::STATUS_OUTSIDE;
            return v;
         end
         if (occ_map[mr*gsc_pkg::GRID_COLS + mc]) return v;
         if (ar == br && ac == bc) continue;
         dr = ar > br ? ar - br : br - ar;
         dc = ac > bc ? ac - bc : bc - ac;
         unsplit = (mx == ax && my == ay) || (mx == bx && my == by);
         if (dr + dc == 1 || unsplit) begin
            if (occ_map[ar*gsc_pkg::GRID_COLS + ac] || occ_map[br*gsc_pkg::GRID_COLS + bc])
               return v;
            continue;
         end
         if (br != mr || bc != mc) begin
            if (lvl >= gsc_pkg::STACK_DEPTH) begin
               v.status = gsc_pkg::STATUS_OVERFLOW;
               return v;
            end
            st_ax[lvl] = mx; st_ay[lvl] = my; st_bx[lvl] = bx; st_by[lvl] = by;
            lvl++;
         end
         if (ar != mr || ac != mc) begin
            if (lvl >= gsc_pkg::STACK_DEPTH) begin
               v.status = gsc_pkg::STATUS_OVERFLOW;
               return v;
            end
            st_ax[lvl] = ax; st_ay[lvl] = ay; st_bx[lvl] = mx; st_by[lvl] = my;
            lvl++;
         end
      end
      v.is_clear = 1'b1;
      return v;
   endfunction

   // Expected answer for one accepted transaction; updates the shadow map on writes.
   function automatic gsc_pkg::rsp_type predict_clearance(input gsc_pkg::req_type t);
      gsc_pkg::rsp_type v;
      if (t.cmd == gsc_pkg::CMD_WRITE) begin
         occ_map[int'(t.cell_row)*gsc_pkg::GRID_COLS + int'(t.cell_col)] = t.cell_occupied;
         v.is_clear = 1'b0;
         v.status = gsc_pkg::STATUS_OK;
         return v;
      end
      return segment_verdict(t.start_x, t.start_y, t.end_x, t.end_y);
   endfunction

   function automatic gsc_pkg::req_type cell_write(input int r, input int c, input bit o);
      gsc_pkg::req_type t;
      logic [159:0]     noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = noise[$bits(gsc_pkg::req_type)-1:0];
      t.cmd = gsc_pkg::CMD_WRITE;
      t.cell_row = 6'(r); t.cell_col = 6'(c); t.cell_occupied = o;
      return t;
   endfunction

   function automatic gsc_pkg::req_type seg_query(input longint sx, input longint sy,
                                                  input longint ex, input longint ey);
      gsc_pkg::req_type t;
      logic [159:0]     noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = noise[$bits(gsc_pkg::req_type)-1:0];
      t.cmd = gsc_pkg::CMD_QUERY;
      t.start_x = sx[31:0]; t.start_y = sy[31:0];
      t.end_x = ex[31:0]; t.end_y = ey[31:0];
      return t;
   endfunction

   // Default scale: one cell is 3276.8 raw units; place a point mid-cell.
   function automatic longint mid_of(input int idx);
      return longint'(idx) * 3277 + 1638;
   endfunction

   // Random point: mostly inside the grid for the current settings, some just off it.
   function automatic longint rand_coord(input longint org);
      longint span;
      int     pick;
      span = (longint'(gsc_pkg::GRID_COLS) << 32) / longint'(cpm);
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      if (span < 1) span = 1;
      pick = $urandom_range(99);
      if (pick < 80) return org + longint'({$urandom, $urandom} % span);
      if (pick < 90) return org - 1 - longint'($urandom_range(32'(span / 8 + 1)));
      if (pick < 95) return org + span + longint'($urandom_range(32'(span / 8 + 1)));
      return longint'($urandom);
   endfunction

   function automatic gsc_pkg::req_type rand_item();
      longint sx, sy;
      if ($urandom_range(99) < 30)
         return cell_write($urandom_range(gsc_pkg::GRID_ROWS-1),
                           $urandom_range(gsc_pkg::GRID_COLS-1),
                           $urandom_range(99) < 30);
      sx = rand_coord(org_x);
      sy = rand_coord(org_y);
      // Some short hops to reach the side-by-side and same-cell endings.
      if ($urandom_range(99) < 20)
         return seg_query(sx, sy, sx + $urandom_range(4000), sy - $urandom_range(4000));
      return seg_query(sx, sy, rand_coord(org_x), rand_coord(org_y));
   endfunction

   task automatic add_item(input gsc_pkg::req_type t);
      pending_items = {pending_items, t};
   endtask

   // Driver: offer pending transactions, hold payload until accepted, idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) due_answers = {due_answers, predict_clearance(req_data)};
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each answer against the oldest expectation, stall at random.
   always @(posedge clock) begin
      gsc_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected answer: is_clear=%0d status=%0d",
                           rsp_data.is_clear, rsp_data.status);
            end else begin
               want = due_answers.pop_front();
               if (rsp_data.is_clear !== want.is_clear || rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: is_clear exp %0d got %0d, status exp %0d got %0d",
                              want.is_clear, rsp_data.is_clear, want.status, rsp_data.status);
               end
            end
         end
         // Long hold-off: lets the block fill up and push back on the sender.
         if (hold_go) hold_left = 400;
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
         if (hold_left > 0) hold_left--;
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() > 0 || req_valid || due_answers.size() > 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_settings(input longint ox, input longint oy, input bit [31:0] c);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= gsc_pkg::CSR_ORIGIN_X; csr_wdata <= ox[31:0];
      @(posedge clock);
      csr_index <= gsc_pkg::CSR_ORIGIN_Y; csr_wdata <= oy[31:0];
      @(posedge clock);
      csr_index <= gsc_pkg::CSR_CPM; csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      org_x = longint'(signed'(ox[31:0]));
      org_y = longint'(signed'(oy[31:0]));
      cpm = c;
   endtask

   task automatic queue_random(input int n);
      repeat (n) add_item(rand_item());
   endtask

   initial begin
      org_x = 0; org_y = 0; cpm = gsc_pkg::CPM_RESET;
      foreach (occ_map[i]) occ_map[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners, equal points, outside, blocked midpoint, neighbors, same cell.
      add_item(cell_write(0, 0, 1'b0));
      add_item(cell_write(gsc_pkg::GRID_ROWS-1, gsc_pkg::GRID_COLS-1, 1'b1));
      add_item(cell_write(0, gsc_pkg::GRID_COLS-1, 1'b0));
      add_item(cell_write(10, 10, 1'b1));
      add_item(seg_query(1000, 1000, 1000, 1000));
      add_item(seg_query(-1, 0, 5000, 5000));
      add_item(seg_query(32'h7FFF_FFFF, 0, 0, 0));
      add_item(seg_query(-64'sh8000_0000, -64'sh8000_0000, 64'h7FFF_FFFF, 64'h7FFF_FFFF));
      add_item(seg_query(mid_of(5), mid_of(10), mid_of(15), mid_of(10)));
      add_item(seg_query(mid_of(20), mid_of(20), mid_of(21), mid_of(20)));
      add_item(seg_query(mid_of(9), mid_of(10), mid_of(10), mid_of(10)));
      add_item(seg_query(mid_of(30), mid_of(30), mid_of(30) + 500, mid_of(30) - 300));
      add_item(seg_query(mid_of(0), mid_of(0), mid_of(62), mid_of(60)));
      add_item(seg_query(mid_of(0), mid_of(0), mid_of(63), mid_of(63)));
      add_item(seg_query(mid_of(40), mid_of(40), mid_of(40), mid_of(40)+1));
      add_item(seg_query(mid_of(40), mid_of(40), mid_of(41), mid_of(41)));
      add_item(seg_query(0, 0, 209715, 0));
      add_item(seg_query(0, 0, 209716, 0));
      add_item(cell_write(10, 10, 1'b0));
      add_item(seg_query(mid_of(5), mid_of(10), mid_of(15), mid_of(10)));
      queue_random(60);
      wait_drained();

      // Queue more items and hold the receiver off while the sender keeps going.
      queue_random(30);
      @(posedge clock);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      queue_random(40);
      wait_drained();

      // Shifted origin, no idling on either side.
      write_settings(-64'sh2_0000, 64'sh1_0000, gsc_pkg::CPM_RESET);
      idle_pct = 0;
      queue_random(90);
      wait_drained();
      idle_pct = 10;

      // Finest scale.
      write_settings(0, 0, 32'hFFFF_FFFF);
      queue_random(80);
      wait_drained();

      // Coarsest scale from the lowest origin.
      write_settings(-64'sh8000_0000, -64'sh8000_0000, 32'd1);
      queue_random(70);
      wait_drained();

      // Highest origin: only the corner point itself can be inside.
      write_settings(64'h7FFF_FFFF, 64'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_random(30);
      add_item(seg_query(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFE));
      wait_drained();

      // Odd origin and coarse cells, then back to reset values.
      write_settings(64'sh1_2345, -64'sh4000, 32'd327680);
      queue_random(90);
      wait_drained();
      write_settings(0, 0, gsc_pkg::CPM_RESET);
      queue_random(90);
      wait_drained();

      if (mismatches == 0 && due_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
